### hw/rtl/lfu_pkg.sv
// Shared types and constants for the LFU key/value store.
// Used by the top level and lfu_scan; depends on nothing.
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam int ENTRIES_DEFAULT     = 16;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int STAMP_WIDTH_DEFAULT = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // read_value returned by a get that misses
    localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
        logic                      evicted;
        logic signed [KEY_W-1:0]   evicted_key;
    } rsp_t;

    // what the scan has found so far
    typedef struct packed {
        logic match;
        logic victim;
        logic free;
    } scan_flags_t;

endpackage

### hw/rtl/lfu_cache_replacement.sv
// Top level of the LFU key/value store: sequencer, entry RAM and scan unit.
// Depends on lfu_pkg, lfu_ram and lfu_scan.

// Fully associative key/value store of ENTRIES entries with least-frequently-used
// replacement and least-recently-used tie break. Entries live in one RAM word each
// (valid, key, value, use count, access stamp). After reset the block sweeps the RAM
// clear and holds req_stall high meanwhile; the capacity register can be written at
// any time it is idle. Each request transaction is then served by a scan that reads
// one entry per cycle through the RAM read port into a shared compare unit: one read
// per entry in ST_SCAN, then ST_DRAIN, then the decide/write-back state, which waits
// while the previous response is still stalled, plus one more write when an eviction
// frees a slot other than the one the new key goes to. The response waits in an
// output register, so the next request is taken while it is still stalled.
module lfu_cache_replacement #(
    parameter int ENTRIES     = lfu_pkg::ENTRIES_DEFAULT,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEFAULT,
    parameter int STAMP_WIDTH = lfu_pkg::STAMP_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  lfu_pkg::req_t            req,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output lfu_pkg::rsp_t            rsp,
    input  logic                     cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wr_data
);

    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W     = $clog2(ENTRIES + 1);
    localparam int STAMP_LSB = 0;
    localparam int COUNT_LSB = STAMP_LSB + STAMP_WIDTH;
    localparam int VALUE_LSB = COUNT_LSB + COUNT_WIDTH;
    localparam int KEY_LSB   = VALUE_LSB + lfu_pkg::VALUE_W;
    localparam int VALID_BIT = KEY_LSB + lfu_pkg::KEY_W;
    localparam int WORD_W    = VALID_BIT + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_INVAL  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic                       data_en_reg;
    logic [IDX_W-1:0]           data_idx_reg;
    lfu_pkg::req_t              req_reg, req_next;
    logic [lfu_pkg::CAP_W-1:0]  cap_reg;
    logic [STAMP_WIDTH-1:0]     clock_reg, clock_next;
    logic [OCC_W-1:0]           occ_reg, occ_next;
    lfu_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic                       scan_start;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [WORD_W-1:0]          wr_data;
    logic                       rd_en;
    logic [WORD_W-1:0]          rd_data;

    lfu_pkg::scan_flags_t       flags;
    logic [IDX_W-1:0]           match_idx;
    logic [lfu_pkg::VALUE_W-1:0] match_value;
    logic [COUNT_WIDTH-1:0]     match_count;
    logic [IDX_W-1:0]           victim_idx;
    logic [lfu_pkg::KEY_W-1:0]  victim_key;
    logic [IDX_W-1:0]           free_idx;

    logic [OCC_W-1:0]           limit;
    logic                       do_evict;
    logic                       have_slot;
    logic [IDX_W-1:0]           ins_idx;
    logic [COUNT_WIDTH-1:0]     bumped_count;
    logic [STAMP_WIDTH-1:0]     stamp;
    logic                       out_free;

    lfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    lfu_scan #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .data_en     (data_en_reg),
        .data_idx    (data_idx_reg),
        .key         (req_reg.key),
        .ent_valid   (rd_data[VALID_BIT]),
        .ent_key     (rd_data[KEY_LSB +: lfu_pkg::KEY_W]),
        .ent_value   (rd_data[VALUE_LSB +: lfu_pkg::VALUE_W]),
        .ent_count   (rd_data[COUNT_LSB +: COUNT_WIDTH]),
        .ent_stamp   (rd_data[STAMP_LSB +: STAMP_WIDTH]),
        .flags       (flags),
        .match_idx   (match_idx),
        .match_value (match_value),
        .match_count (match_count),
        .victim_idx  (victim_idx),
        .victim_key  (victim_key),
        .free_idx    (free_idx)
    );

    // capacity above the entry count acts as the entry count
    assign limit = (32'(cap_reg) > ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(cap_reg);

    assign do_evict     = (occ_reg >= limit) && flags.victim;
    assign have_slot    = do_evict || flags.free;
    // new key goes to the lowest slot that is free once the victim is dropped
    assign ins_idx      = (do_evict && !(flags.free && (free_idx < victim_idx))) ?
                          victim_idx : free_idx;
    assign bumped_count = (match_count == '1) ? match_count : match_count + 1'b1;
    assign stamp        = clock_reg + 1'b1;
    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign rd_en        = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        scan_idx_next  = scan_idx_reg;
        req_next       = req_reg;
        clock_next     = clock_reg;
        occ_next       = occ_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        scan_start     = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = clr_idx_reg;
        wr_data        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    scan_start    = 1'b1;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // hold until the previous response has left
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    state_next           = ST_IDLE;
                    if (req_reg.mode == lfu_pkg::MODE_GET)
                    begin
                        if (flags.match)
                        begin
                            rsp_next.hit        = 1'b1;
                            rsp_next.read_value = match_value;
                            wr_en               = 1'b1;
                            wr_addr             = match_idx;
                            wr_data             = {1'b1, req_reg.key, match_value,
                                                   bumped_count, stamp};
                            clock_next          = stamp;
                        end
                        else
                        begin
                            rsp_next.read_value = lfu_pkg::MISS_VALUE;
                        end
                    end
                    else if (limit != '0)
                    begin
                        if (flags.match)
                        begin
                            rsp_next.hit = 1'b1;
                            wr_en        = 1'b1;
                            wr_addr      = match_idx;
                            wr_data      = {1'b1, req_reg.key, req_reg.write_value,
                                            bumped_count, stamp};
                            clock_next   = stamp;
                        end
                        else
                        begin
                            if (do_evict)
                            begin
                                rsp_next.evicted     = 1'b1;
                                rsp_next.evicted_key = victim_key;
                                if (ins_idx != victim_idx)
                                begin
                                    state_next = ST_INVAL;
                                end
                            end
                            if (have_slot)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ins_idx;
                                wr_data    = {1'b1, req_reg.key, req_reg.write_value,
                                              COUNT_WIDTH'(1), stamp};
                                clock_next = stamp;
                            end
                            occ_next = occ_reg - OCC_W'(do_evict) + OCC_W'(have_slot);
                        end
                    end
                end
            end
            ST_INVAL:
            begin
                // drop the victim; the new key went to a lower free slot
                wr_en      = 1'b1;
                wr_addr    = victim_idx;
                wr_data    = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            scan_idx_reg  <= '0;
            data_en_reg   <= 1'b0;
            cap_reg       <= lfu_pkg::CAP_RESET;
            clock_reg     <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            scan_idx_reg  <= scan_idx_next;
            data_en_reg   <= (state_reg == ST_SCAN);
            clock_reg     <= clock_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        data_idx_reg <= scan_idx_reg;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/lfu_scan.sv
// Shared compare unit: looks at one stored entry per cycle while data_en is high
// and keeps the key match, the LFU/LRU victim and the first free slot. Uses lfu_pkg.
module lfu_scan #(
    parameter int ENTRIES     = lfu_pkg::ENTRIES_DEFAULT,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEFAULT,
    parameter int STAMP_WIDTH = lfu_pkg::STAMP_WIDTH_DEFAULT,
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              data_en,
    input  logic [IDX_W-1:0]                  data_idx,
    input  logic [lfu_pkg::KEY_W-1:0]         key,
    input  logic                              ent_valid,
    input  logic [lfu_pkg::KEY_W-1:0]         ent_key,
    input  logic [lfu_pkg::VALUE_W-1:0]       ent_value,
    input  logic [COUNT_WIDTH-1:0]            ent_count,
    input  logic [STAMP_WIDTH-1:0]            ent_stamp,
    output lfu_pkg::scan_flags_t              flags,
    output logic [IDX_W-1:0]                  match_idx,
    output logic [lfu_pkg::VALUE_W-1:0]       match_value,
    output logic [COUNT_WIDTH-1:0]            match_count,
    output logic [IDX_W-1:0]                  victim_idx,
    output logic [lfu_pkg::KEY_W-1:0]         victim_key,
    output logic [IDX_W-1:0]                  free_idx
);

    lfu_pkg::scan_flags_t          flags_reg, flags_next;
    logic [IDX_W-1:0]              match_idx_reg, match_idx_next;
    logic [lfu_pkg::VALUE_W-1:0]   match_value_reg, match_value_next;
    logic [COUNT_WIDTH-1:0]        match_count_reg, match_count_next;
    logic [IDX_W-1:0]              victim_idx_reg, victim_idx_next;
    logic [lfu_pkg::KEY_W-1:0]     victim_key_reg, victim_key_next;
    logic [COUNT_WIDTH-1:0]        victim_count_reg, victim_count_next;
    logic [STAMP_WIDTH-1:0]        victim_stamp_reg, victim_stamp_next;
    logic [IDX_W-1:0]              free_idx_reg, free_idx_next;
    logic                          older;

    // smaller count wins; equal counts fall back to the older stamp
    assign older = (ent_count < victim_count_reg) ||
                   ((ent_count == victim_count_reg) && (ent_stamp < victim_stamp_reg));

    always_comb
    begin
        flags_next        = flags_reg;
        match_idx_next    = match_idx_reg;
        match_value_next  = match_value_reg;
        match_count_next  = match_count_reg;
        victim_idx_next   = victim_idx_reg;
        victim_key_next   = victim_key_reg;
        victim_count_next = victim_count_reg;
        victim_stamp_next = victim_stamp_reg;
        free_idx_next     = free_idx_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else if (data_en)
        begin
            if (ent_valid && (ent_key == key) && !flags_reg.match)
            begin
                flags_next.match = 1'b1;
                match_idx_next   = data_idx;
                match_value_next = ent_value;
                match_count_next = ent_count;
            end
            if (!ent_valid && !flags_reg.free)
            begin
                flags_next.free = 1'b1;
                free_idx_next   = data_idx;
            end
            // strict compare keeps the lowest index on a full tie
            if (ent_valid && (!flags_reg.victim || older))
            begin
                flags_next.victim = 1'b1;
                victim_idx_next   = data_idx;
                victim_key_next   = ent_key;
                victim_count_next = ent_count;
                victim_stamp_next = ent_stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg    <= match_idx_next;
        match_value_reg  <= match_value_next;
        match_count_reg  <= match_count_next;
        victim_idx_reg   <= victim_idx_next;
        victim_key_reg   <= victim_key_next;
        victim_count_reg <= victim_count_next;
        victim_stamp_reg <= victim_stamp_next;
        free_idx_reg     <= free_idx_next;
    end

    assign flags       = flags_reg;
    assign match_idx   = match_idx_reg;
    assign match_value = match_value_reg;
    assign match_count = match_count_reg;
    assign victim_idx  = victim_idx_reg;
    assign victim_key  = victim_key_reg;
    assign free_idx    = free_idx_reg;

endmodule
